[rtl/core/mtr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor throttle ramp package
// Shared widths, codes and types of the throttle ramp generator.
// ----------------------------------------------------------------------------
package mtr_pkg;

    localparam int FULL_SCALE = 100000;
    localparam int RATE_SLOW  = FULL_SCALE * 6 / 1000;
    localparam int RATE_HIGH  = FULL_SCALE * 2 / 1000;
    localparam int THRESH     = FULL_SCALE / 10000;

    localparam int MOTOR_W  = 3;
    localparam int TARGET_W = 19;
    localparam int TEMPO_W  = 2;
    localparam int PWM_W    = 18;
    localparam int STATUS_W = 2;

    localparam int THR_W   = 17;
    localparam int POS_W   = 20;
    localparam int MAG_W   = 19;
    localparam int DIVR_W  = 11;
    localparam int INC_W   = 11;
    localparam int STEP_W  = 12;
    localparam int STEPS_W = 11;
    localparam int CNT_W   = 5;

    localparam logic MODE_CMD  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam logic [TEMPO_W-1:0] TEMPO_INSTANT = 2'd0;
    localparam logic [TEMPO_W-1:0] TEMPO_SLOW    = 2'd1;
    localparam logic [TEMPO_W-1:0] TEMPO_HIGH    = 2'd2;
    localparam logic [TEMPO_W-1:0] TEMPO_UNKNOWN = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TEMPO = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_MOTOR = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BUSY  = 2'd3;

    localparam logic [CNT_W-1:0] DIV_STEPS_COUNT = CNT_W'(MAG_W);
    localparam logic [CNT_W-1:0] DIV_INC_COUNT   = CNT_W'(INC_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV_STEPS,
        ST_DIV_INC,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic              start;
        logic [CNT_W-1:0]  count;
        logic [DIVR_W-1:0] rem_init;
        logic [MAG_W-1:0]  bits;
        logic [DIVR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] quot;
    } div_rsp_t;

endpackage

[rtl/core/mtr_cmd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor throttle ramp command channel
// Valid/ready channel that carries command and tick beats.
// ----------------------------------------------------------------------------
interface mtr_cmd_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 mode;
    logic [mtr_pkg::MOTOR_W-1:0]          motor_index;
    logic signed [mtr_pkg::TARGET_W-1:0]  target_throttle;
    logic [mtr_pkg::TEMPO_W-1:0]          tempo;

    modport source (output valid, output mode, output motor_index,
                    output target_throttle, output tempo, input ready);
    modport sink   (input valid, input mode, input motor_index,
                    input target_throttle, input tempo, output ready);
endinterface

[rtl/core/mtr_res_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor throttle ramp result channel
// Valid/ready channel that carries PWM write and error beats.
// ----------------------------------------------------------------------------
interface mtr_res_if;
    logic                           valid;
    logic                           ready;
    logic [mtr_pkg::MOTOR_W-1:0]    out_motor;
    logic [mtr_pkg::PWM_W-1:0]      pwm_value;
    logic                           ramp_done;
    logic [mtr_pkg::STATUS_W-1:0]   status;

    modport source (output valid, output out_motor, output pwm_value,
                    output ramp_done, output status, input ready);
    modport sink   (input valid, input out_motor, input pwm_value,
                    input ramp_done, input status, output ready);
endinterface

[rtl/core/mtr_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor throttle ramp serial divider
// Restoring divider that shifts in one dividend bit and produces one
// quotient bit per cycle, for a requested number of bits.
// ----------------------------------------------------------------------------
module mtr_div (
    input  logic              clk,
    input  logic              rst_n,
    input  mtr_pkg::div_req_t req,
    output mtr_pkg::div_rsp_t rsp
);

    logic [mtr_pkg::DIVR_W-1:0] rem_reg, rem_next;
    logic [mtr_pkg::MAG_W-1:0]  bits_reg, bits_next;
    logic [mtr_pkg::MAG_W-1:0]  quot_reg, quot_next;
    logic [mtr_pkg::DIVR_W-1:0] divisor_reg, divisor_next;
    logic [mtr_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;

    logic [mtr_pkg::DIVR_W:0]   trial;
    logic [mtr_pkg::DIVR_W:0]   diff;
    logic                       fits;

    always_comb
    begin
        trial = {rem_reg, bits_reg[mtr_pkg::MAG_W-1]};
        diff  = trial - {1'b0, divisor_reg};
        fits  = (trial >= {1'b0, divisor_reg});
    end

    always_comb
    begin
        rem_next     = rem_reg;
        bits_next    = bits_reg;
        quot_next    = quot_reg;
        divisor_next = divisor_reg;
        cnt_next     = cnt_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        if (req.start)
        begin
            rem_next     = req.rem_init;
            bits_next    = req.bits;
            quot_next    = '0;
            divisor_next = req.divisor;
            cnt_next     = req.count;
            busy_next    = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[mtr_pkg::DIVR_W-1:0] : trial[mtr_pkg::DIVR_W-1:0];
            bits_next = {bits_reg[mtr_pkg::MAG_W-2:0], 1'b0};
            quot_next = {quot_reg[mtr_pkg::MAG_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == mtr_pkg::CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        bits_reg    <= bits_next;
        quot_reg    <= quot_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

[rtl/core/motor_throttle_ramp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor throttle ramp generator
// Keeps a clamped throttle per motor, ramps it linearly toward a target in
// steps driven by tick beats, and emits a PWM value for every write.
// ----------------------------------------------------------------------------
// The block takes one beat at a time. A tick that writes, an instant command
// or an error passes through the evaluate and emit states into the result
// register, and the next beat is accepted once the block is back in idle. An
// idle tick or an ignored command returns to idle straight from evaluation. A
// command that starts a ramp runs the shared bit-serial divider twice, nineteen
// quotient bits for the step count and eleven for the increment, before its
// result is registered and the next beat can be accepted. A change smaller
// than one step skips the second division. The result register holds a
// finished beat while the next beat is accepted; the block waits only when a
// new result is ready and the previous one is still held.
module motor_throttle_ramp #(
    parameter int MOTOR_COUNT = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    mtr_cmd_if.sink   cmd,
    mtr_res_if.source res
);

    localparam int IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
    localparam int SLOTS = 1 << IDX_W;

    mtr_pkg::state_t state_reg, state_next;

    logic                               mode_reg;
    logic [mtr_pkg::MOTOR_W-1:0]        motor_reg;
    logic signed [mtr_pkg::TARGET_W-1:0] target_reg;
    logic [mtr_pkg::TEMPO_W-1:0]        tempo_reg;

    logic [mtr_pkg::THR_W-1:0]          throttle_reg [SLOTS];
    logic                               ramp_active_reg, ramp_active_next;
    logic [IDX_W-1:0]                   ramp_motor_reg, ramp_motor_next;
    logic signed [mtr_pkg::POS_W-1:0]   ramp_position_reg, ramp_position_next;
    logic signed [mtr_pkg::STEP_W-1:0]  ramp_step_reg, ramp_step_next;
    logic [mtr_pkg::STEPS_W-1:0]        steps_left_reg, steps_left_next;
    logic signed [mtr_pkg::POS_W-1:0]   ramp_goal_reg, ramp_goal_next;

    logic [mtr_pkg::MAG_W-1:0]          mag_reg, mag_next;
    logic                               neg_reg, neg_next;
    logic [mtr_pkg::STEPS_W-1:0]        steps_reg, steps_next;

    logic [mtr_pkg::MOTOR_W-1:0]        wr_motor_reg, wr_motor_next;
    logic signed [mtr_pkg::POS_W-1:0]   wr_value_reg, wr_value_next;
    logic                               wr_done_reg, wr_done_next;
    logic [mtr_pkg::STATUS_W-1:0]       wr_status_reg, wr_status_next;

    logic                               res_valid_reg, res_valid_next;
    logic [mtr_pkg::MOTOR_W-1:0]        res_motor_reg;
    logic [mtr_pkg::PWM_W-1:0]          res_pwm_reg;
    logic                               res_done_reg;
    logic [mtr_pkg::STATUS_W-1:0]       res_status_reg;

    mtr_pkg::div_req_t                  div_req;
    mtr_pkg::div_rsp_t                  div_rsp;

    logic [mtr_pkg::THR_W-1:0]          cur_throttle;
    logic signed [mtr_pkg::POS_W-1:0]   target_ext;
    logic signed [mtr_pkg::POS_W-1:0]   change;
    logic [mtr_pkg::MAG_W-1:0]          mag;
    logic                               bad_motor;
    logic                               eval_emit;
    logic                               eval_div;
    logic signed [mtr_pkg::POS_W-1:0]   tick_position;
    logic [mtr_pkg::STEP_W-1:0]         inc_ext;
    logic signed [mtr_pkg::STEP_W-1:0]  new_step;
    logic signed [mtr_pkg::POS_W-1:0]   new_position;
    logic                               steps_zero;
    logic                               res_free;
    logic                               emit_load;
    logic [mtr_pkg::THR_W-1:0]          wr_clamped;
    logic [mtr_pkg::DIVR_W-1:0]         rate;

    mtr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        cur_throttle = throttle_reg[motor_reg[IDX_W-1:0]];
        target_ext   = mtr_pkg::POS_W'(target_reg);
        change       = target_ext - $signed({3'b000, cur_throttle});
        mag          = change[mtr_pkg::POS_W-1] ? mtr_pkg::MAG_W'(-change)
                                                 : mtr_pkg::MAG_W'(change);
        bad_motor    = ({1'b0, motor_reg} >= (mtr_pkg::MOTOR_W + 1)'(MOTOR_COUNT));
        rate         = (tempo_reg == mtr_pkg::TEMPO_SLOW) ?
                       mtr_pkg::DIVR_W'(mtr_pkg::RATE_SLOW) :
                       mtr_pkg::DIVR_W'(mtr_pkg::RATE_HIGH);
        eval_emit    = 1'b0;
        eval_div     = 1'b0;
        if (mode_reg == mtr_pkg::MODE_TICK)
        begin
            eval_emit = ramp_active_reg;
        end
        else if (ramp_active_reg || (tempo_reg == mtr_pkg::TEMPO_UNKNOWN) || bad_motor ||
                 (tempo_reg == mtr_pkg::TEMPO_INSTANT))
        begin
            eval_emit = 1'b1;
        end
        else if (mag >= mtr_pkg::MAG_W'(mtr_pkg::THRESH))
        begin
            eval_div = 1'b1;
        end
        tick_position = ramp_position_reg +
                        $signed({{(mtr_pkg::POS_W - mtr_pkg::STEP_W){ramp_step_reg[mtr_pkg::STEP_W-1]}},
                                 ramp_step_reg});
        inc_ext      = {1'b0, div_rsp.quot[mtr_pkg::INC_W-1:0]};
        new_step     = neg_reg ? $signed(-inc_ext) : $signed(inc_ext);
        new_position = $signed({3'b000, cur_throttle}) +
                       $signed({{(mtr_pkg::POS_W - mtr_pkg::STEP_W){new_step[mtr_pkg::STEP_W-1]}},
                                new_step});
        steps_zero   = (div_rsp.quot == '0);
        res_free     = !res_valid_reg || res.ready;
        emit_load    = (state_reg == mtr_pkg::ST_EMIT) && res_free;
        if (wr_value_reg > mtr_pkg::POS_W'(mtr_pkg::FULL_SCALE))
        begin
            wr_clamped = mtr_pkg::THR_W'(mtr_pkg::FULL_SCALE);
        end
        else if (wr_value_reg[mtr_pkg::POS_W-1])
        begin
            wr_clamped = '0;
        end
        else
        begin
            wr_clamped = wr_value_reg[mtr_pkg::THR_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mtr_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = mtr_pkg::ST_EVAL;
                end
            end
            mtr_pkg::ST_EVAL:
            begin
                if (eval_div)
                begin
                    state_next = mtr_pkg::ST_DIV_STEPS;
                end
                else if (eval_emit)
                begin
                    state_next = mtr_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = mtr_pkg::ST_IDLE;
                end
            end
            mtr_pkg::ST_DIV_STEPS:
            begin
                if (div_rsp.done)
                begin
                    state_next = steps_zero ? mtr_pkg::ST_EMIT : mtr_pkg::ST_DIV_INC;
                end
            end
            mtr_pkg::ST_DIV_INC:
            begin
                if (div_rsp.done)
                begin
                    state_next = mtr_pkg::ST_EMIT;
                end
            end
            mtr_pkg::ST_EMIT:
            begin
                if (res_free)
                begin
                    state_next = mtr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mtr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ramp_active_next   = ramp_active_reg;
        ramp_motor_next    = ramp_motor_reg;
        ramp_position_next = ramp_position_reg;
        ramp_step_next     = ramp_step_reg;
        steps_left_next    = steps_left_reg;
        ramp_goal_next     = ramp_goal_reg;
        mag_next           = mag_reg;
        neg_next           = neg_reg;
        steps_next         = steps_reg;
        wr_motor_next      = wr_motor_reg;
        wr_value_next      = wr_value_reg;
        wr_done_next       = wr_done_reg;
        wr_status_next     = wr_status_reg;
        div_req            = '0;
        unique case (state_reg)
            mtr_pkg::ST_EVAL:
            begin
                wr_motor_next  = motor_reg;
                wr_value_next  = target_ext;
                wr_done_next   = 1'b0;
                wr_status_next = mtr_pkg::STATUS_OK;
                mag_next       = mag;
                neg_next       = change[mtr_pkg::POS_W-1];
                if (mode_reg == mtr_pkg::MODE_TICK)
                begin
                    wr_motor_next = mtr_pkg::MOTOR_W'(ramp_motor_reg);
                    if (steps_left_reg != '0)
                    begin
                        ramp_position_next = tick_position;
                        steps_left_next    = steps_left_reg - 1'b1;
                        wr_value_next      = tick_position;
                    end
                    else
                    begin
                        ramp_active_next = 1'b0;
                        wr_value_next    = ramp_goal_reg;
                        wr_done_next     = 1'b1;
                    end
                end
                else if (ramp_active_reg)
                begin
                    wr_status_next = mtr_pkg::STATUS_BUSY;
                end
                else if (tempo_reg == mtr_pkg::TEMPO_UNKNOWN)
                begin
                    wr_status_next = mtr_pkg::STATUS_TEMPO;
                end
                else if (bad_motor)
                begin
                    wr_status_next = mtr_pkg::STATUS_MOTOR;
                end
                else if (tempo_reg == mtr_pkg::TEMPO_INSTANT)
                begin
                    wr_done_next = 1'b1;
                end
                if (eval_div)
                begin
                    div_req.start    = 1'b1;
                    div_req.count    = mtr_pkg::DIV_STEPS_COUNT;
                    div_req.rem_init = '0;
                    div_req.bits     = mag;
                    div_req.divisor  = rate;
                end
            end
            mtr_pkg::ST_DIV_STEPS:
            begin
                if (div_rsp.done)
                begin
                    steps_next = div_rsp.quot[mtr_pkg::STEPS_W-1:0];
                    if (steps_zero)
                    begin
                        wr_done_next = 1'b1;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.count    = mtr_pkg::DIV_INC_COUNT;
                        div_req.rem_init = mtr_pkg::DIVR_W'(mag_reg[mtr_pkg::MAG_W-1:mtr_pkg::INC_W]);
                        div_req.bits     = {mag_reg[mtr_pkg::INC_W-1:0],
                                            (mtr_pkg::MAG_W - mtr_pkg::INC_W)'(0)};
                        div_req.divisor  = div_rsp.quot[mtr_pkg::DIVR_W-1:0];
                    end
                end
            end
            mtr_pkg::ST_DIV_INC:
            begin
                if (div_rsp.done)
                begin
                    ramp_active_next   = 1'b1;
                    ramp_motor_next    = motor_reg[IDX_W-1:0];
                    ramp_goal_next     = target_ext;
                    ramp_step_next     = new_step;
                    ramp_position_next = new_position;
                    steps_left_next    = steps_reg - 1'b1;
                    wr_value_next      = new_position;
                    wr_done_next       = 1'b0;
                end
            end
            mtr_pkg::ST_IDLE, mtr_pkg::ST_EMIT:
            begin
            end
            default:
            begin
            end
        endcase
        res_valid_next = res_valid_reg;
        if (emit_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= mtr_pkg::ST_IDLE;
            res_valid_reg     <= 1'b0;
            ramp_active_reg   <= 1'b0;
            ramp_motor_reg    <= '0;
            ramp_position_reg <= '0;
            ramp_step_reg     <= '0;
            steps_left_reg    <= '0;
            ramp_goal_reg     <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                throttle_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg         <= state_next;
            res_valid_reg     <= res_valid_next;
            ramp_active_reg   <= ramp_active_next;
            ramp_motor_reg    <= ramp_motor_next;
            ramp_position_reg <= ramp_position_next;
            ramp_step_reg     <= ramp_step_next;
            steps_left_reg    <= steps_left_next;
            ramp_goal_reg     <= ramp_goal_next;
            if (emit_load && (wr_status_reg == mtr_pkg::STATUS_OK))
            begin
                throttle_reg[wr_motor_reg[IDX_W-1:0]] <= wr_clamped;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            mode_reg   <= cmd.mode;
            motor_reg  <= cmd.motor_index;
            target_reg <= cmd.target_throttle;
            tempo_reg  <= cmd.tempo;
        end
        mag_reg       <= mag_next;
        neg_reg       <= neg_next;
        steps_reg     <= steps_next;
        wr_motor_reg  <= wr_motor_next;
        wr_value_reg  <= wr_value_next;
        wr_done_reg   <= wr_done_next;
        wr_status_reg <= wr_status_next;
        if (emit_load)
        begin
            res_motor_reg  <= wr_motor_reg;
            res_done_reg   <= wr_done_reg;
            res_status_reg <= wr_status_reg;
            res_pwm_reg    <= (wr_status_reg == mtr_pkg::STATUS_OK) ?
                              (mtr_pkg::PWM_W'(wr_clamped) + mtr_pkg::PWM_W'(mtr_pkg::FULL_SCALE)) :
                              '0;
        end
    end

    assign cmd.ready     = (state_reg == mtr_pkg::ST_IDLE);
    assign res.valid     = res_valid_reg;
    assign res.out_motor = res_motor_reg;
    assign res.pwm_value = res_pwm_reg;
    assign res.ramp_done = res_done_reg;
    assign res.status    = res_status_reg;

    // A pending step count is only ever held while a ramp is running.
    a_steps_need_ramp: assert property (@(posedge clk) disable iff (!rst_n)
        (steps_left_reg != '0) |-> ramp_active_reg)
        else $error("steps left without an active ramp");

    // A ramp starts only when the increment division completes.
    a_ramp_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ramp_active_reg) |-> $past(state_reg == mtr_pkg::ST_DIV_INC))
        else $error("ramp started outside the increment division");

    // The divider reports completion only to a state that waits for it.
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == mtr_pkg::ST_DIV_STEPS ||
                          state_reg == mtr_pkg::ST_DIV_INC))
        else $error("divider finished while no division was pending");

    // A throttle write always addresses an existing motor.
    a_write_motor: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_load && (wr_status_reg == mtr_pkg::STATUS_OK)) |->
        ({1'b0, wr_motor_reg} < (mtr_pkg::MOTOR_W + 1)'(MOTOR_COUNT)))
        else $error("throttle write to a nonexistent motor");

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor throttle ramp testbench
// Drives command and tick beats into the throttle ramp generator and checks
// every PWM and error beat against an in-bench model of the per-motor
// throttles and the active ramp. A directed part covers clamping, errors,
// the small-change threshold and short ramps. Random parts follow, under
// changing idle patterns, a long result stall and a full drain.
// ----------------------------------------------------------------------------
module tb;

    localparam int NUM_MOTORS    = 4;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;

    typedef struct packed {
        logic                         mode;
        logic [mtr_pkg::MOTOR_W-1:0]  motor;
        logic [mtr_pkg::TARGET_W-1:0] target;
        logic [mtr_pkg::TEMPO_W-1:0]  tempo;
    } cmd_beat_t;

    typedef struct packed {
        logic [mtr_pkg::MOTOR_W-1:0]  motor;
        logic [mtr_pkg::PWM_W-1:0]    pwm;
        logic                         done;
        logic [mtr_pkg::STATUS_W-1:0] status;
    } pwm_beat_t;

    logic clk;
    logic rst_n;

    mtr_cmd_if cmd();
    mtr_res_if res();

    motor_throttle_ramp #(
        .MOTOR_COUNT(NUM_MOTORS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res)
    );

    logic [mtr_pkg::THR_W-1:0]          throttle_q [NUM_MOTORS];
    logic                               ramping;
    logic [1:0]                         ramp_mtr;
    logic signed [mtr_pkg::POS_W-1:0]   ramp_pos;
    logic signed [mtr_pkg::STEP_W-1:0]  ramp_inc;
    logic [mtr_pkg::STEPS_W-1:0]        ramp_left;
    logic signed [mtr_pkg::POS_W-1:0]   ramp_goal;

    pwm_beat_t pending_pwm [$];

    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_left      = 0;
    int cycle_count    = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
                hold_left <= hold_left - 1;
        end
    end

    function automatic pwm_beat_t store_throttle(input int mtr, input int value,
                                                 input logic done);
        pwm_beat_t r;
        int v;
        v = value;
        if (v > mtr_pkg::FULL_SCALE)
            v = mtr_pkg::FULL_SCALE;
        else if (v < 0)
            v = 0;
        throttle_q[mtr] = mtr_pkg::THR_W'(v);
        r.motor  = mtr_pkg::MOTOR_W'(mtr);
        r.pwm    = mtr_pkg::PWM_W'(v + mtr_pkg::FULL_SCALE);
        r.done   = done;
        r.status = mtr_pkg::STATUS_OK;
        return r;
    endfunction

    function automatic pwm_beat_t fault_beat(input logic [mtr_pkg::MOTOR_W-1:0] motor,
                                             input logic [mtr_pkg::STATUS_W-1:0] status);
        pwm_beat_t r;
        r.motor  = motor;
        r.pwm    = '0;
        r.done   = 1'b0;
        r.status = status;
        return r;
    endfunction

    task automatic clear_throttles();
        for (int i = 0; i < NUM_MOTORS; i++)
            throttle_q[i] = '0;
        ramping   = 1'b0;
        ramp_mtr  = '0;
        ramp_pos  = '0;
        ramp_inc  = '0;
        ramp_left = '0;
        ramp_goal = '0;
    endtask

    task automatic predict_ramp(input cmd_beat_t b, output bit produced);
        int target;
        int change;
        int mag;
        int rate;
        int steps;
        produced = 1'b1;
        if (b.mode == mtr_pkg::MODE_TICK)
        begin
            if (!ramping)
                produced = 1'b0;
            else if (ramp_left != 0)
            begin
                ramp_pos  = ramp_pos + ramp_inc;
                ramp_left = ramp_left - 1'b1;
                pending_pwm.push_back(store_throttle(int'(ramp_mtr), int'(ramp_pos), 1'b0));
            end
            else
            begin
                ramping = 1'b0;
                pending_pwm.push_back(store_throttle(int'(ramp_mtr), int'(ramp_goal), 1'b1));
            end
        end
        else if (ramping)
            pending_pwm.push_back(fault_beat(b.motor, mtr_pkg::STATUS_BUSY));
        else if (b.tempo == mtr_pkg::TEMPO_UNKNOWN)
            pending_pwm.push_back(fault_beat(b.motor, mtr_pkg::STATUS_TEMPO));
        else if (b.motor >= NUM_MOTORS)
            pending_pwm.push_back(fault_beat(b.motor, mtr_pkg::STATUS_MOTOR));
        else
        begin
            target = int'($signed(b.target));
            if (b.tempo == mtr_pkg::TEMPO_INSTANT)
                pending_pwm.push_back(store_throttle(int'(b.motor), target, 1'b1));
            else
            begin
                rate   = (b.tempo == mtr_pkg::TEMPO_SLOW) ? mtr_pkg::RATE_SLOW
                                                          : mtr_pkg::RATE_HIGH;
                change = target - int'(throttle_q[b.motor]);
                mag    = (change < 0) ? -change : change;
                steps  = mag / rate;
                if (mag < mtr_pkg::THRESH)
                    produced = 1'b0;
                else if (steps == 0)
                    pending_pwm.push_back(store_throttle(int'(b.motor), target, 1'b1));
                else
                begin
                    ramping   = 1'b1;
                    ramp_mtr  = b.motor[1:0];
                    ramp_goal = mtr_pkg::POS_W'(target);
                    ramp_inc  = mtr_pkg::STEP_W'(change / steps);
                    ramp_pos  = mtr_pkg::POS_W'(int'(throttle_q[b.motor]) + change / steps);
                    ramp_left = mtr_pkg::STEPS_W'(steps - 1);
                    pending_pwm.push_back(store_throttle(int'(b.motor), int'(ramp_pos), 1'b0));
                end
            end
        end
    endtask

    function automatic cmd_beat_t make_cmd(input int motor, input int target,
                                           input logic [mtr_pkg::TEMPO_W-1:0] tempo);
        cmd_beat_t b;
        b.mode   = mtr_pkg::MODE_CMD;
        b.motor  = mtr_pkg::MOTOR_W'(motor);
        b.target = mtr_pkg::TARGET_W'(target);
        b.tempo  = tempo;
        return b;
    endfunction

    function automatic cmd_beat_t tick_beat();
        cmd_beat_t b;
        b.mode   = mtr_pkg::MODE_TICK;
        b.motor  = mtr_pkg::MOTOR_W'($urandom);
        b.target = mtr_pkg::TARGET_W'($urandom);
        b.tempo  = mtr_pkg::TEMPO_W'($urandom);
        return b;
    endfunction

    function automatic cmd_beat_t random_cmd();
        cmd_beat_t b;
        int pick;
        int base;
        int t;
        b.mode = mtr_pkg::MODE_CMD;
        if ($urandom_range(0, 4) == 0)
            b.motor = mtr_pkg::MOTOR_W'($urandom_range(NUM_MOTORS, 7));
        else
            b.motor = mtr_pkg::MOTOR_W'($urandom_range(0, NUM_MOTORS - 1));
        pick = $urandom_range(0, 99);
        if (pick < 25)
            b.tempo = mtr_pkg::TEMPO_INSTANT;
        else if (pick < 55)
            b.tempo = mtr_pkg::TEMPO_SLOW;
        else if (pick < 85)
            b.tempo = mtr_pkg::TEMPO_HIGH;
        else
            b.tempo = mtr_pkg::TEMPO_UNKNOWN;
        base = int'(throttle_q[b.motor % NUM_MOTORS]);
        pick = $urandom_range(0, 99);
        if (b.tempo == mtr_pkg::TEMPO_INSTANT || pick < 3)
        begin
            if ($urandom_range(0, 9) < 8)
                t = int'($urandom_range(0, 300000)) - 100000;
            else
                t = int'($signed(mtr_pkg::TARGET_W'($urandom)));
        end
        else if (pick < 50)
            t = base + int'($urandom_range(0, 40)) - 20;
        else
            t = base + int'($urandom_range(0, 6000)) - 3000;
        b.target = mtr_pkg::TARGET_W'(t);
        return b;
    endfunction

    function automatic cmd_beat_t random_beat();
        bit tick;
        if (ramping)
            tick = ($urandom_range(0, 9) != 0);
        else
            tick = ($urandom_range(0, 6) == 0);
        return tick ? tick_beat() : random_cmd();
    endfunction

    task automatic drive_beat(input cmd_beat_t b, output bit produced);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd.valid <= 1'b0;
            @(posedge clk);
        end
        cmd.valid           <= 1'b1;
        cmd.mode            <= b.mode;
        cmd.motor_index     <= b.motor;
        cmd.target_throttle <= b.target;
        cmd.tempo           <= b.tempo;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        predict_ramp(b, produced);
    endtask

    task automatic report_fault(input string what, input pwm_beat_t want,
                                input pwm_beat_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0t %s: expected motor %0d pwm %0d done %0b status %0d",
                     $time, what, want.motor, want.pwm, want.done, want.status);
            $display("    got motor %0d pwm %0d done %0b status %0d",
                     got.motor, got.pwm, got.done, got.status);
        end
    endtask

    initial
    begin
        pwm_beat_t got;
        pwm_beat_t want;
        res.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res.valid && res.ready)
            begin
                got.motor  = res.out_motor;
                got.pwm    = res.pwm_value;
                got.done   = res.ramp_done;
                got.status = res.status;
                if (pending_pwm.size() == 0)
                    report_fault("unexpected beat", '0, got);
                else
                begin
                    want = pending_pwm.pop_front();
                    if (got.motor !== want.motor || got.pwm !== want.pwm ||
                        got.done !== want.done || got.status !== want.status)
                        report_fault("mismatch", want, got);
                end
            end
            res.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic finish_ramp();
        bit produced;
        while (ramping)
            drive_beat(tick_beat(), produced);
    endtask

    task automatic test_directed();
        bit produced;
        drive_beat(tick_beat(), produced);
        drive_beat(make_cmd(0, 200000, mtr_pkg::TEMPO_INSTANT), produced);
        drive_beat(make_cmd(1, -100000, mtr_pkg::TEMPO_INSTANT), produced);
        drive_beat(make_cmd(2, 262143, mtr_pkg::TEMPO_INSTANT), produced);
        drive_beat(make_cmd(2, -262144, mtr_pkg::TEMPO_INSTANT), produced);
        drive_beat(make_cmd(3, 50000, mtr_pkg::TEMPO_INSTANT), produced);
        drive_beat(make_cmd(7, 1000, mtr_pkg::TEMPO_SLOW), produced);
        drive_beat(make_cmd(4, 1000, mtr_pkg::TEMPO_HIGH), produced);
        drive_beat(make_cmd(5, 1000, mtr_pkg::TEMPO_UNKNOWN), produced);
        drive_beat(make_cmd(0, 1000, mtr_pkg::TEMPO_UNKNOWN), produced);
        drive_beat(make_cmd(0, 100005, mtr_pkg::TEMPO_SLOW), produced);
        drive_beat(make_cmd(0, 99991, mtr_pkg::TEMPO_HIGH), produced);
        drive_beat(make_cmd(0, 99700, mtr_pkg::TEMPO_SLOW), produced);
        drive_beat(make_cmd(3, 51037, mtr_pkg::TEMPO_HIGH), produced);
        drive_beat(make_cmd(2, 0, mtr_pkg::TEMPO_INSTANT), produced);
        drive_beat(make_cmd(6, 0, mtr_pkg::TEMPO_UNKNOWN), produced);
        finish_ramp();
        drive_beat(make_cmd(1, -700, mtr_pkg::TEMPO_SLOW), produced);
        finish_ramp();
        drive_beat(make_cmd(2, 1300, mtr_pkg::TEMPO_SLOW), produced);
        finish_ramp();
    endtask

    task automatic test_random(input int send_pct, input int recv_pct, input int beats);
        int counted;
        bit produced;
        counted       = 0;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        while (counted < beats)
        begin
            drive_beat(random_beat(), produced);
            if (produced)
                counted++;
        end
    endtask

    task automatic test_backpressure();
        bit produced;
        hold_left <= HOLD_CYCLES;
        repeat (20)
            drive_beat(random_beat(), produced);
    endtask

    task automatic test_drain_pause();
        test_random(send_idle_pct, recv_idle_pct, 10);
        cmd.valid <= 1'b0;
        while (pending_pwm.size() != 0)
            @(posedge clk);
        test_random(send_idle_pct, recv_idle_pct, 10);
    endtask

    initial
    begin
        rst_n               <= 1'b0;
        cmd.valid           <= 1'b0;
        cmd.mode            <= mtr_pkg::MODE_CMD;
        cmd.motor_index     <= '0;
        cmd.target_throttle <= '0;
        cmd.tempo           <= mtr_pkg::TEMPO_INSTANT;
        clear_throttles();
        send_idle_pct = 18;
        recv_idle_pct = 56;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random(18, 56, 120);
        test_backpressure();
        test_random(56, 18, 120);
        test_drain_pause();
        test_random(0, 0, 120);
        cmd.valid <= 1'b0;
        while (pending_pwm.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/mtr_pkg.sv
rtl/core/mtr_cmd_if.sv
rtl/core/mtr_res_if.sv
rtl/core/mtr_div.sv
rtl/core/motor_throttle_ramp.sv
bench/tb.sv
